### rtl/subtractive_synth_voice_macros.svh
// assertion macros for the subtractive synth voice
// used by the rtl files that carry assertions; needs signals clock and reset in scope
`ifndef SUBTRACTIVE_SYNTH_VOICE_MACROS_SVH
`define SUBTRACTIVE_SYNTH_VOICE_MACROS_SVH
`ifndef SYNTHESIS
`define SSV_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("ssv assertion failed");
`define SSV_ASSERT_IMPL(lbl, pre, post) \
   `SSV_ASSERT(lbl, (pre) |-> (post))
`else
`define SSV_ASSERT(lbl, prop)
`define SSV_ASSERT_IMPL(lbl, pre, post)
`endif
`endif

### rtl/ssv_pkg.sv
// shared types and constants of the subtractive synth voice
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ssv_pkg;
   localparam int SINE_TABLE_BITS = 10;
   localparam int TANH_TABLE_BITS = 10;
   localparam int COEF_TABLE_BITS = 10;
   localparam int CUTOFF_FLOOR    = 4;
   localparam int CUTOFF_CEILING  = 31207;
   localparam int MULT_W          = 34;
   localparam int QUO_BITS        = 22;

   localparam logic [63:0] ONE30       = 64'd1 << 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] TWO_PI_Q30  = 64'd6746518853;

   typedef enum logic [2:0] {
      CSR_OSC_A_INC, CSR_OSC_B_INC, CSR_LFO_INC, CSR_LFO_DEPTH,
      CSR_CUTOFF_BASE, CSR_CUTOFF_ENV, CSR_RESONANCE, CSR_OUTPUT_GAIN
   } csr_index_type;

   typedef enum logic [1:0] {TABLE_SINE, TABLE_TANH, TABLE_COEF} table_kind_type;

   typedef enum logic [1:0] {BLEP_NONE, BLEP_START, BLEP_END} blep_region_type;

   typedef enum logic [4:0] {
      S_IDLE, S_LFO, S_DEPTH, S_FACTOR, S_INCA, S_INCB, S_PHA, S_PHB, S_G,
      S_BLEP_CHK, S_BLEP_DIV, S_BLEP_SQ, S_FB, S_X, S_TLOOK, S_POLE_M, S_POLE_A,
      S_OUT1, S_OUT2, S_OUT3, S_OUT4, S_DONE
   } state_type;
endpackage
`default_nettype wire

### rtl/ssv_rom.sv
// constant lookup table (sine, tanh or filter coefficient) with registered read
// depends on ssv_pkg
`timescale 1ns / 1ps
`default_nettype none
module ssv_rom #(
   parameter ssv_pkg::table_kind_type KIND = ssv_pkg::TABLE_SINE,
   parameter int BITS   = 10,
   parameter int DATA_W = 16,
   localparam int DEPTH  = (KIND == ssv_pkg::TABLE_SINE) ? (1 << BITS) : (1 << BITS) + 1,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic [ADDR_W-1:0] addr,
   output logic [DATA_W-1:0] data
);
   typedef logic [31:0] rom_type [DEPTH];

   // long division by shift and subtract, only used while the table is built
   function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [63:0] r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], num[b]};
         if (r >= den) begin
            r    = r - den;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // exp(-z), z in q30, by series of exp(-z/16) squared four times
   function automatic logic [63:0] neg_exp(input logic [63:0] z);
      logic [63:0] w;
      logic [63:0] sum;
      logic [63:0] term;
      w = z >> 4;
      sum = ssv_pkg::ONE30;
      term = ssv_pkg::ONE30;
      for (int n = 1; n <= 12; n++) begin
         term = udiv((term * w) >> 30, 64'(n));
         if (n % 2 == 1) begin
            sum = (term > sum) ? 64'd0 : sum - term;
         end else begin
            sum = sum + term;
         end
      end
      for (int k = 0; k < 4; k++) begin
         sum = (sum * sum + (ssv_pkg::ONE30 >> 1)) >> 30;
      end
      return sum;
   endfunction

   function automatic rom_type build();
      rom_type r;
      logic [63:0] j, x, sum, term, v, e, den;
      int unsigned half, quarter;
      half = (1 << BITS) >> 1;
      quarter = (1 << BITS) >> 2;
      for (int unsigned i = 0; i < DEPTH; i++) begin
         case (KIND)
            ssv_pkg::TABLE_SINE: begin
               j = 64'(i & (half - 1));
               if (j > 64'(quarter)) begin
                  j = 64'(half) - j;
               end
               x = (ssv_pkg::HALF_PI_Q30 * j) >> (BITS - 2);
               sum = x;
               term = x;
               for (int m = 1; m <= 7; m++) begin
                  term = udiv((((term * x) >> 30) * x) >> 30, 64'((2 * m) * (2 * m + 1)));
                  if (m % 2 == 1) begin
                     sum = (term > sum) ? 64'd0 : sum - term;
                  end else begin
                     sum = sum + term;
                  end
               end
               v = (sum * 64'd32767 + (ssv_pkg::ONE30 >> 1)) >> 30;
               if (v > 64'd32767) begin
                  v = 64'd32767;
               end
               r[i] = (i >= half) ? 32'(64'd0 - v) : 32'(v);
            end
            ssv_pkg::TABLE_TANH: begin
               e = neg_exp(64'(i) << (33 - BITS));
               den = ssv_pkg::ONE30 + e;
               r[i] = 32'(udiv(((ssv_pkg::ONE30 - e) << 22) + (den >> 1), den));
            end
            default: begin
               e = neg_exp((ssv_pkg::TWO_PI_Q30 * 64'(i)) >> (BITS + 1));
               r[i] = 32'(ssv_pkg::ONE30 - e);
            end
         endcase
      end
      return r;
   endfunction

   localparam rom_type ROM = build();

   always_ff @(posedge clock) begin
      data <= ROM[addr][DATA_W-1:0];
   end
endmodule
`default_nettype wire

### rtl/ssv_mult.sv
// shared signed multiplier with registered product
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module ssv_mult #(
   parameter int W = 34
) (
   input  logic                  clock,
   input  logic signed [W-1:0]   a,
   input  logic signed [W-1:0]   b,
   output logic signed [2*W-1:0] prod
);
   logic signed [2*W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= a * b;
   end

   assign prod = prod_ff;
endmodule
`default_nettype wire

### rtl/ssv_divider.sv
// bit-serial restoring divider for numerator below denominator, one quotient bit a cycle
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module ssv_divider #(
   parameter int QB = 22
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [31:0]   numer,
   input  logic [31:0]   denom,
   output logic          done,
   output logic [QB-1:0] quo
);
   localparam int CW = $clog2(QB);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   rem_ff, rem_in;
   logic [31:0]   den_ff, den_in;
   logic [QB-1:0] quo_ff, quo_in;
   logic [32:0]   shifted;
   logic [32:0]   diff;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      shifted  = {rem_ff, 1'b0};
      diff     = shifted - {1'b0, den_ff};
      if (start) begin
         busy_in  = 1'b1;
         count_in = CW'(QB - 1);
         rem_in   = numer;
         den_in   = denom;
      end else if (busy_ff) begin
         // remainder stays below the denominator, so one compare settles each bit
         if (!diff[32]) begin
            rem_in = diff[31:0];
            quo_in = {quo_ff[QB-2:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            quo_in = {quo_ff[QB-2:0], 1'b0};
         end
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      quo_ff   <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
endmodule
`default_nettype wire

### rtl/subtractive_synth_voice.sv
// subtractive synth voice: lfo, two polyblep saws, tanh ladder filter, output shaper
// depends on ssv_pkg, ssv_rom, ssv_mult, ssv_divider and the macro header
// a tick runs through the sequencer states; an oscillator whose phase sits in a blep region adds
//   a pass through the 22-bit serial divider and the square
// a new request is accepted only in idle, after the previous sample has gone to the output register
// reset: synchronous, active high; clears phases, filter stages and restores register defaults
`timescale 1ns / 1ps
`default_nettype none
`include "subtractive_synth_voice_macros.svh"
module subtractive_synth_voice #(
   parameter int SINE_TABLE_BITS = ssv_pkg::SINE_TABLE_BITS,
   parameter int TANH_TABLE_BITS = ssv_pkg::TANH_TABLE_BITS,
   parameter int COEF_TABLE_BITS = ssv_pkg::COEF_TABLE_BITS
) (
   input  logic        clock,
   input  logic        reset,
   // request: tdata = envelope_level[15:0]; tuser = note_start
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        req_tuser,
   // response: tdata = sample_out[15:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   localparam int MW          = ssv_pkg::MULT_W;
   localparam int QB          = ssv_pkg::QUO_BITS;
   localparam int SB          = SINE_TABLE_BITS;
   localparam int TB          = TANH_TABLE_BITS;
   localparam int CB          = COEF_TABLE_BITS;
   localparam int FB          = 15 - CB;        // cutoff bits below the table index
   localparam int TANH_SHIFT  = 24 - TB;

   // configuration registers
   logic [30:0]        osc_a_inc_ff, osc_b_inc_ff, lfo_inc_ff;
   logic [15:0]        lfo_depth_ff, output_gain_ff;
   logic [14:0]        cutoff_base_ff, resonance_ff;
   logic signed [15:0] cutoff_env_ff;

   // voice state
   logic [31:0]        lfo_phase_ff, lfo_phase_in;
   logic [31:0]        phase_a_ff, phase_a_in;
   logic [31:0]        phase_b_ff, phase_b_in;
   logic signed [23:0] stage_ff [4];
   logic signed [23:0] stage_in [4];

   // working registers of one tick
   ssv_pkg::state_type       state_ff, state_in;
   ssv_pkg::blep_region_type region_ff, region_in;
   logic [15:0]        env_ff, env_in;
   logic [32:0]        factor_ff, factor_in;
   logic [31:0]        inc_a_ff, inc_a_in, inc_b_ff, inc_b_in;
   logic [14:0]        fc_ff, fc_in;
   logic [30:0]        c0_ff, c0_in, g_ff, g_in;
   logic signed [25:0] vco_ff, vco_in;
   logic               sel_ff, sel_in;
   logic               neg_ff, neg_in;
   logic signed [23:0] pin_ff, pin_in;
   logic [1:0]         pole_ff, pole_in;
   logic signed [15:0] res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_data_ff, rsp_data_in;

   // shared units
   logic signed [MW-1:0]   mul_a, mul_b;
   logic signed [2*MW-1:0] prod;
   logic                   div_start, div_done;
   logic [31:0]            div_numer, div_denom;
   logic [QB-1:0]          div_quo;

   logic [SB-1:0]      sine_addr;
   logic [15:0]        sine_data;
   logic [TB:0]        tanh_addr;
   logic [22:0]        tanh_data;
   logic [CB:0]        coef_addr;
   logic [30:0]        coef_data;

   // combinational helpers
   logic signed [28:0] tanh_arg;
   logic [33:0]        factor_sum;
   logic signed [18:0] fc_sum;
   logic [31:0]        blep_t, blep_dt;
   logic signed [25:0] naive, corr, saw;
   logic [CB:0]        fc_idx;
   logic signed [26:0] x_val;
   logic signed [24:0] pole_diff;
   logic signed [23:0] new_stage;
   logic [23:0]        round_sum;
   logic [16:0]        out_mag;

   function automatic logic [TB:0] tanh_index(input logic signed [28:0] arg);
      logic [28:0] mag;
      logic [28:0] sh;
      mag = arg[28] ? 29'(-arg) : 29'(arg);
      sh = mag >> TANH_SHIFT;
      if (sh > 29'(1 << TB)) begin
         return (TB + 1)'(1 << TB);
      end
      return sh[TB:0];
   endfunction

   ssv_mult #(.W(MW)) u_mult (
      .clock(clock), .a(mul_a), .b(mul_b), .prod(prod)
   );

   ssv_divider #(.QB(QB)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .numer(div_numer),
      .denom(div_denom), .done(div_done), .quo(div_quo)
   );

   ssv_rom #(.KIND(ssv_pkg::TABLE_SINE), .BITS(SB), .DATA_W(16)) u_sine (
      .clock(clock), .addr(sine_addr), .data(sine_data)
   );

   ssv_rom #(.KIND(ssv_pkg::TABLE_TANH), .BITS(TB), .DATA_W(23)) u_tanh (
      .clock(clock), .addr(tanh_addr), .data(tanh_data)
   );

   ssv_rom #(.KIND(ssv_pkg::TABLE_COEF), .BITS(CB), .DATA_W(31)) u_coef (
      .clock(clock), .addr(coef_addr), .data(coef_data)
   );

   assign sine_addr  = lfo_phase_ff[31 -: SB];
   assign fc_idx     = {1'b0, fc_ff[14:FB]};
   assign req_tready = (state_ff == ssv_pkg::S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // sequencer and datapath
   always_comb begin
      state_in     = state_ff;
      region_in    = region_ff;
      lfo_phase_in = lfo_phase_ff;
      phase_a_in   = phase_a_ff;
      phase_b_in   = phase_b_ff;
      for (int i = 0; i < 4; i++) begin
         stage_in[i] = stage_ff[i];
      end
      env_in       = env_ff;
      factor_in    = factor_ff;
      inc_a_in     = inc_a_ff;
      inc_b_in     = inc_b_ff;
      fc_in        = fc_ff;
      c0_in        = c0_ff;
      g_in         = g_ff;
      vco_in       = vco_ff;
      sel_in       = sel_ff;
      neg_in       = neg_ff;
      pin_in       = pin_ff;
      pole_in      = pole_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      mul_a      = '0;
      mul_b      = '0;
      div_start  = 1'b0;
      coef_addr  = fc_idx;
      tanh_arg   = '0;

      blep_t     = sel_ff ? phase_b_ff : phase_a_ff;
      blep_dt    = sel_ff ? inc_b_ff : inc_a_ff;
      div_numer  = blep_t;
      div_denom  = blep_dt;
      naive      = 26'($signed({3'b0, blep_t[31:9]})) - 26'sd4194304;
      corr       = '0;
      saw        = naive;
      factor_sum = {2'b0, 32'h8000_0000} + prod[33:0];
      fc_sum     = 19'($signed({1'b0, cutoff_base_ff})) + 19'($signed(prod[33:16]));
      x_val      = 27'(vco_ff) - 27'($signed(prod[38:13]));
      pole_diff  = 25'(pin_ff) - 25'(stage_ff[pole_ff]);
      new_stage  = stage_ff[pole_ff] + $signed(prod[53:30]);
      round_sum  = {1'b0, tanh_data} + 24'd64;
      out_mag    = round_sum[23:7];

      unique case (state_ff)
         ssv_pkg::S_IDLE: begin
            if (req_tvalid) begin
               env_in = req_tdata;
               // note start clears phases and filter before this tick
               if (req_tuser) begin
                  phase_a_in   = '0;
                  phase_b_in   = '0;
                  lfo_phase_in = {1'b0, lfo_inc_ff};
                  for (int i = 0; i < 4; i++) begin
                     stage_in[i] = '0;
                  end
               end else begin
                  lfo_phase_in = lfo_phase_ff + {1'b0, lfo_inc_ff};
               end
               state_in = ssv_pkg::S_LFO;
            end
         end
         ssv_pkg::S_LFO: begin
            state_in = ssv_pkg::S_DEPTH;   // sine table read in flight
         end
         ssv_pkg::S_DEPTH: begin
            mul_a    = MW'($signed(sine_data));
            mul_b    = MW'(lfo_depth_ff);
            state_in = ssv_pkg::S_FACTOR;
         end
         ssv_pkg::S_FACTOR: begin
            factor_in = factor_sum[32:0];
            mul_a     = MW'(env_ff);
            mul_b     = MW'(cutoff_env_ff);
            state_in  = ssv_pkg::S_INCA;
         end
         ssv_pkg::S_INCA: begin
            // clamp the modulated cutoff
            if (fc_sum < 19'(ssv_pkg::CUTOFF_FLOOR)) begin
               fc_in = 15'(ssv_pkg::CUTOFF_FLOOR);
            end else if (fc_sum > 19'(ssv_pkg::CUTOFF_CEILING)) begin
               fc_in = 15'(ssv_pkg::CUTOFF_CEILING);
            end else begin
               fc_in = fc_sum[14:0];
            end
            mul_a    = MW'(osc_a_inc_ff);
            mul_b    = MW'(factor_ff);
            state_in = ssv_pkg::S_INCB;
         end
         ssv_pkg::S_INCB: begin
            inc_a_in = prod[62:31];
            mul_a    = MW'(osc_b_inc_ff);
            mul_b    = MW'(factor_ff);
            state_in = ssv_pkg::S_PHA;
         end
         ssv_pkg::S_PHA: begin
            inc_b_in   = prod[62:31];
            phase_a_in = phase_a_ff + inc_a_ff;
            c0_in      = coef_data;
            coef_addr  = fc_idx + 1'b1;
            state_in   = ssv_pkg::S_PHB;
         end
         ssv_pkg::S_PHB: begin
            phase_b_in = phase_b_ff + inc_b_ff;
            mul_a      = MW'(coef_data - c0_ff);
            mul_b      = MW'(fc_ff[FB-1:0]);
            state_in   = ssv_pkg::S_G;
         end
         ssv_pkg::S_G: begin
            g_in     = c0_ff + prod[FB +: 31];
            vco_in   = '0;
            sel_in   = 1'b0;
            state_in = ssv_pkg::S_BLEP_CHK;
         end
         ssv_pkg::S_BLEP_CHK: begin
            // start of period wins when both regions match
            if (blep_t < blep_dt) begin
               region_in = ssv_pkg::BLEP_START;
               div_numer = blep_t;
               div_start = 1'b1;
               state_in  = ssv_pkg::S_BLEP_DIV;
            end else if (({1'b0, blep_t} + {1'b0, blep_dt}) > 33'h1_0000_0000) begin
               region_in = ssv_pkg::BLEP_END;
               div_numer = 32'd0 - blep_t;
               div_start = 1'b1;
               state_in  = ssv_pkg::S_BLEP_DIV;
            end else begin
               region_in = ssv_pkg::BLEP_NONE;
               vco_in    = vco_ff + naive;
               if (!sel_ff) begin
                  sel_in = 1'b1;
               end else begin
                  state_in = ssv_pkg::S_FB;
               end
            end
         end
         ssv_pkg::S_BLEP_DIV: begin
            if (div_done) begin
               mul_a    = MW'(div_quo);
               mul_b    = MW'(div_quo);
               state_in = ssv_pkg::S_BLEP_SQ;
            end
         end
         ssv_pkg::S_BLEP_SQ: begin
            if (region_ff == ssv_pkg::BLEP_START) begin
               corr = 26'({div_quo, 1'b0}) - 26'(prod[43:22]) - 26'sd4194304;
            end else begin
               corr = 26'(prod[43:22]) - 26'({div_quo, 1'b0}) + 26'sd4194304;
            end
            saw    = naive - corr;
            vco_in = vco_ff + saw;
            if (!sel_ff) begin
               sel_in   = 1'b1;
               state_in = ssv_pkg::S_BLEP_CHK;
            end else begin
               state_in = ssv_pkg::S_FB;
            end
         end
         ssv_pkg::S_FB: begin
            mul_a    = MW'(stage_ff[3]);
            mul_b    = MW'(resonance_ff);
            state_in = ssv_pkg::S_X;
         end
         ssv_pkg::S_X: begin
            tanh_arg = 29'(x_val);
            neg_in   = x_val[26];
            state_in = ssv_pkg::S_TLOOK;
         end
         ssv_pkg::S_TLOOK: begin
            pin_in   = neg_ff ? -24'($signed({1'b0, tanh_data}))
                              : 24'($signed({1'b0, tanh_data}));
            pole_in  = '0;
            state_in = ssv_pkg::S_POLE_M;
         end
         ssv_pkg::S_POLE_M: begin
            mul_a    = MW'(pole_diff);
            mul_b    = MW'(g_ff);
            state_in = ssv_pkg::S_POLE_A;
         end
         ssv_pkg::S_POLE_A: begin
            // each stage feeds the next one
            stage_in[pole_ff] = new_stage;
            pin_in            = new_stage;
            if (pole_ff == 2'd3) begin
               state_in = ssv_pkg::S_OUT1;
            end else begin
               pole_in  = pole_ff + 1'b1;
               state_in = ssv_pkg::S_POLE_M;
            end
         end
         ssv_pkg::S_OUT1: begin
            mul_a    = MW'(stage_ff[3]);
            mul_b    = MW'(env_ff);
            state_in = ssv_pkg::S_OUT2;
         end
         ssv_pkg::S_OUT2: begin
            mul_a    = MW'($signed(prod[39:16]));
            mul_b    = MW'(output_gain_ff);
            state_in = ssv_pkg::S_OUT3;
         end
         ssv_pkg::S_OUT3: begin
            tanh_arg = $signed(prod[40:12]);
            neg_in   = prod[40];
            state_in = ssv_pkg::S_OUT4;
         end
         ssv_pkg::S_OUT4: begin
            if (out_mag > 17'd32767) begin
               res_in = neg_ff ? -16'sd32767 : 16'sd32767;
            end else begin
               res_in = neg_ff ? -$signed(out_mag[15:0]) : $signed(out_mag[15:0]);
            end
            state_in = ssv_pkg::S_DONE;
         end
         ssv_pkg::S_DONE: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ssv_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ssv_pkg::S_IDLE;
         end
      endcase

      tanh_addr = tanh_index(tanh_arg);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ssv_pkg::S_IDLE;
         rsp_valid_ff   <= 1'b0;
         lfo_phase_ff   <= '0;
         phase_a_ff     <= '0;
         phase_b_ff     <= '0;
         for (int i = 0; i < 4; i++) begin
            stage_ff[i] <= '0;
         end
         osc_a_inc_ff   <= '0;
         osc_b_inc_ff   <= '0;
         lfo_inc_ff     <= '0;
         lfo_depth_ff   <= '0;
         cutoff_base_ff <= 15'd16384;
         cutoff_env_ff  <= '0;
         resonance_ff   <= '0;
         output_gain_ff <= 16'd4096;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         lfo_phase_ff <= lfo_phase_in;
         phase_a_ff   <= phase_a_in;
         phase_b_ff   <= phase_b_in;
         for (int i = 0; i < 4; i++) begin
            stage_ff[i] <= stage_in[i];
         end
         // register write transaction
         if (csr_valid) begin
            unique case (ssv_pkg::csr_index_type'(csr_index))
               ssv_pkg::CSR_OSC_A_INC:   osc_a_inc_ff   <= csr_data[30:0];
               ssv_pkg::CSR_OSC_B_INC:   osc_b_inc_ff   <= csr_data[30:0];
               ssv_pkg::CSR_LFO_INC:     lfo_inc_ff     <= csr_data[30:0];
               ssv_pkg::CSR_LFO_DEPTH:   lfo_depth_ff   <= csr_data[15:0];
               ssv_pkg::CSR_CUTOFF_BASE: cutoff_base_ff <= csr_data[14:0];
               ssv_pkg::CSR_CUTOFF_ENV:  cutoff_env_ff  <= $signed(csr_data[15:0]);
               ssv_pkg::CSR_RESONANCE:   resonance_ff   <= csr_data[14:0];
               ssv_pkg::CSR_OUTPUT_GAIN: output_gain_ff <= csr_data[15:0];
               default: begin
               end
            endcase
         end
      end
      region_ff   <= region_in;
      env_ff      <= env_in;
      factor_ff   <= factor_in;
      inc_a_ff    <= inc_a_in;
      inc_b_ff    <= inc_b_in;
      fc_ff       <= fc_in;
      c0_ff       <= c0_in;
      g_ff        <= g_in;
      vco_ff      <= vco_in;
      sel_ff      <= sel_in;
      neg_ff      <= neg_in;
      pin_ff      <= pin_in;
      pole_ff     <= pole_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // a request transaction always starts a multi-cycle tick
   `SSV_ASSERT(a_accept_busy, (req_tvalid && req_tready) |=> !req_tready)
   // the divider only finishes while the sequencer waits on it
   `SSV_ASSERT_IMPL(a_div_done_state, div_done, state_ff == ssv_pkg::S_BLEP_DIV)
   // a finished sample waits while the output register is still occupied
   `SSV_ASSERT(a_done_hold,
      (state_ff == ssv_pkg::S_DONE && rsp_tvalid && !rsp_tready) |=> (state_ff == ssv_pkg::S_DONE))
endmodule
`default_nettype wire

### test/tb_voice_checker.sv
// checker for the subtractive synth voice: bit-exact sample predictor and response compare
// depends on ssv_pkg; watches the request, response and register channels of the dut
`timescale 1ns / 1ps
module tb_voice_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          fail_count,
   output int          pending_count
);
   localparam int SN = 1 << ssv_pkg::SINE_TABLE_BITS;
   localparam int TN = 1 << ssv_pkg::TANH_TABLE_BITS;
   localparam int CN = 1 << ssv_pkg::COEF_TABLE_BITS;
   localparam int FBITS = 15 - ssv_pkg::COEF_TABLE_BITS;
   localparam longint ONE22 = 64'sd1 << 22;

   longint sine_rom [SN];
   longint tanh_rom [TN + 1];
   longint coef_rom [CN + 1];

   logic [30:0] inc_a_reg, inc_b_reg, inc_lfo_reg;
   logic [15:0] depth_reg, gain_reg;
   logic [14:0] cut_base_reg, reso_reg;
   logic signed [15:0] cut_env_reg;
   logic [31:0] ph_a, ph_b, ph_lfo;
   longint st1, st2, st3, st4;
   logic [15:0] sample_queue [$];

   assign pending_count = sample_queue.size();

   function automatic longint shr_floor(longint v, int sh);
      return v >>> sh;
   endfunction

   function automatic longint unsigned exp_neg(longint unsigned z);
      longint unsigned w, acc, term;
      w = z >> 4;
      acc = ssv_pkg::ONE30;
      term = ssv_pkg::ONE30;
      for (int n = 1; n <= 12; n++) begin
         term = ((term * w) >> 30) / n;
         if (n % 2 == 1) acc = (term > acc) ? 0 : acc - term;
         else acc += term;
      end
      for (int k = 0; k < 4; k++) acc = (acc * acc + (ssv_pkg::ONE30 >> 1)) >> 30;
      return acc;
   endfunction

   function automatic void build_roms();
      longint unsigned x, acc, term, v, e, den, z;
      int j;
      for (int i = 0; i < SN; i++) begin
         j = i & (SN / 2 - 1);
         if (j > SN / 4) j = SN / 2 - j;
         x = (ssv_pkg::HALF_PI_Q30 * j) >> (ssv_pkg::SINE_TABLE_BITS - 2);
         acc = x;
         term = x;
         for (int m = 1; m <= 7; m++) begin
            term = ((((term * x) >> 30) * x) >> 30) / ((2 * m) * (2 * m + 1));
            if (m % 2 == 1) acc = (term > acc) ? 0 : acc - term;
            else acc += term;
         end
         v = (acc * 32767 + (ssv_pkg::ONE30 >> 1)) >> 30;
         if (v > 32767) v = 32767;
         sine_rom[i] = (i >= SN / 2) ? -longint'(v) : longint'(v);
      end
      for (int i = 0; i <= TN; i++) begin
         e = exp_neg(longint'(i) << (33 - ssv_pkg::TANH_TABLE_BITS));
         den = ssv_pkg::ONE30 + e;
         tanh_rom[i] = ((((ssv_pkg::ONE30 - e) << 22) + (den >> 1)) / den);
      end
      for (int i = 0; i <= CN; i++) begin
         z = (ssv_pkg::TWO_PI_Q30 * i) >> (ssv_pkg::COEF_TABLE_BITS + 1);
         coef_rom[i] = ssv_pkg::ONE30 - exp_neg(z);
      end
   endfunction

   function automatic longint tanh_lookup(longint x);
      longint unsigned mag, idx;
      mag = (x < 0) ? -x : x;
      idx = mag >> (24 - ssv_pkg::TANH_TABLE_BITS);
      if (idx > TN) idx = TN;
      return (x < 0) ? -tanh_rom[idx] : tanh_rom[idx];
   endfunction

   // saw with polyblep, start-of-period region checked first
   function automatic longint saw_blep(logic [31:0] t, logic [31:0] dt);
      longint naive, corr;
      longint unsigned u, w;
      naive = longint'(t >> 9) - ONE22;
      corr = 0;
      if (t < dt) begin
         u = (longint'(t) << 22) / dt;
         corr = longint'(2 * u) - longint'((u * u) >> 22) - ONE22;
      end else if (longint'(t) + longint'(dt) > (64'sd1 << 32)) begin
         w = (64'd1 << 32) - t;
         u = (w << 22) / dt;
         corr = longint'((u * u) >> 22) - longint'(2 * u) + ONE22;
      end
      return naive - corr;
   endfunction

   function automatic longint one_pole(longint s, longint in_v, longint g);
      longint r;
      r = s + shr_floor((in_v - s) * g, 30);
      return longint'(int'(r));
   endfunction

   function automatic logic [15:0] voice_sample(logic [15:0] env_in, logic start);
      longint env, lfo, fc, vco, x, fin, v, t, g;
      longint unsigned factor, mag, o;
      logic [31:0] ia, ib;
      int idx, frac;
      env = env_in;
      if (start) begin
         ph_a = 0; ph_b = 0; ph_lfo = 0;
         st1 = 0; st2 = 0; st3 = 0; st4 = 0;
      end
      ph_lfo = ph_lfo + inc_lfo_reg;
      lfo = sine_rom[ph_lfo >> (32 - ssv_pkg::SINE_TABLE_BITS)];
      factor = (64'sd1 << 31) + lfo * longint'(depth_reg);
      ia = 32'((longint'(inc_a_reg) * factor) >> 31);
      ib = 32'((longint'(inc_b_reg) * factor) >> 31);
      ph_a = ph_a + ia;
      ph_b = ph_b + ib;
      vco = saw_blep(ph_a, ia) + saw_blep(ph_b, ib);
      fc = longint'(cut_base_reg) + shr_floor(env * longint'(cut_env_reg), 16);
      if (fc < ssv_pkg::CUTOFF_FLOOR) fc = ssv_pkg::CUTOFF_FLOOR;
      if (fc > ssv_pkg::CUTOFF_CEILING) fc = ssv_pkg::CUTOFF_CEILING;
      idx = int'((fc >> FBITS) & (CN - 1));
      frac = int'(fc & ((1 << FBITS) - 1));
      // the table rises, so the step to the next entry is never negative
      g = coef_rom[idx] + (((coef_rom[idx + 1] - coef_rom[idx]) * frac) >> FBITS);
      x = vco - shr_floor(st4 * longint'(reso_reg), 13);
      fin = tanh_lookup(x);
      st1 = one_pole(st1, fin, g);
      st2 = one_pole(st2, st1, g);
      st3 = one_pole(st3, st2, g);
      st4 = one_pole(st4, st3, g);
      v = shr_floor(shr_floor(st4 * env, 16) * longint'(gain_reg), 12);
      t = tanh_lookup(v);
      mag = (t < 0) ? -t : t;
      o = (mag + 64) >> 7;
      if (o > 32767) o = 32767;
      return (t < 0) ? 16'(-o) : 16'(o);
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   initial build_roms();

   always @(posedge clock) begin
      logic [15:0] want;
      if (reset) begin
         inc_a_reg <= 0; inc_b_reg <= 0; inc_lfo_reg <= 0; depth_reg <= 0;
         cut_base_reg <= 16384; cut_env_reg <= 0; reso_reg <= 0; gain_reg <= 4096;
         ph_a = 0; ph_b = 0; ph_lfo = 0;
         st1 = 0; st2 = 0; st3 = 0; st4 = 0;
         sample_queue.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (ssv_pkg::csr_index_type'(csr_index))
               ssv_pkg::CSR_OSC_A_INC:   inc_a_reg <= csr_data[30:0];
               ssv_pkg::CSR_OSC_B_INC:   inc_b_reg <= csr_data[30:0];
               ssv_pkg::CSR_LFO_INC:     inc_lfo_reg <= csr_data[30:0];
               ssv_pkg::CSR_LFO_DEPTH:   depth_reg <= csr_data[15:0];
               ssv_pkg::CSR_CUTOFF_BASE: cut_base_reg <= csr_data[14:0];
               ssv_pkg::CSR_CUTOFF_ENV:  cut_env_reg <= csr_data[15:0];
               ssv_pkg::CSR_RESONANCE:   reso_reg <= csr_data[14:0];
               ssv_pkg::CSR_OUTPUT_GAIN: gain_reg <= csr_data[15:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (sample_queue.size() == 0) begin
               report_mismatch($sformatf("unexpected sample %h", rsp_tdata));
            end else begin
               want = sample_queue.pop_front();
               if (rsp_tdata !== want)
                  report_mismatch($sformatf("sample_out got %h want %h", rsp_tdata, want));
            end
         end
         if (req_tvalid && req_tready)
            sample_queue.insert(sample_queue.size(), voice_sample(req_tdata, req_tuser));
      end
   end
endmodule

### test/tb_top.sv
// testbench top for the subtractive synth voice: clock, reset, stimulus and verdict
// depends on ssv_pkg, the dut and tb_voice_checker
`timescale 1ns / 1ps
module tb_top;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 120;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [15:0] req_tdata = 0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [15:0] rsp_tdata;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_index = 0;
   logic [31:0] csr_data = 0;
   int          fail_count;
   int          pending_count;
   int          cycle_count = 0;
   int          stall_mode = 0;

   always #1 clock = ~clock;

   subtractive_synth_voice dut (.*);

   tb_voice_checker checker_i (.*);

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // receiver: stall pattern changes between no stall, light and heavy
   always @(negedge clock) begin
      if (stall_mode == 0) rsp_tready <= 1'b1;
      else if (stall_mode == 1) rsp_tready <= ($urandom_range(0, 3) != 0);
      else rsp_tready <= ($urandom_range(0, 3) == 0);
   end

   task automatic write_reg(ssv_pkg::csr_index_type idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait until the checker holds no outstanding samples, then let the block settle
   task automatic drain();
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // one request transaction; valid stays high across back-to-back items when keep_valid is set
   task automatic send_tick(logic [15:0] env, logic start, bit keep_valid);
      req_tvalid <= 1'b1;
      req_tdata <= env;
      req_tuser <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      if (!keep_valid) req_tvalid <= 1'b0;
   endtask

   // bursts of random length with random gaps
   task automatic send_random(int count);
      int burst;
      int env_kind;
      logic [15:0] env;
      burst = 0;
      for (int i = 0; i < count; i++) begin
         if (burst == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clock);
            burst = $urandom_range(1, 12);
            stall_mode = $urandom_range(0, 2);
         end
         env_kind = $urandom_range(0, 9);
         if (env_kind == 0) env = 16'h0000;
         else if (env_kind == 1) env = 16'hffff;
         else env = $urandom;
         burst--;
         send_tick(env, $urandom_range(0, 40) == 0, burst != 0 && i != count - 1);
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic random_setting();
      write_reg(ssv_pkg::CSR_OSC_A_INC,
                $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 26));
      write_reg(ssv_pkg::CSR_OSC_B_INC,
                $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 26));
      write_reg(ssv_pkg::CSR_LFO_INC, $urandom);
      write_reg(ssv_pkg::CSR_LFO_DEPTH, $urandom);
      write_reg(ssv_pkg::CSR_CUTOFF_BASE, $urandom);
      write_reg(ssv_pkg::CSR_CUTOFF_ENV, $urandom);
      write_reg(ssv_pkg::CSR_RESONANCE, $urandom);
      write_reg(ssv_pkg::CSR_OUTPUT_GAIN, $urandom);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: defaults, then silence with zero increments
      send_tick(16'h0000, 1'b1, 0);
      send_tick(16'hffff, 1'b0, 0);
      drain();
      // zero increment on a, large increment just below half period on b
      write_reg(ssv_pkg::CSR_OSC_A_INC, 32'h0000_0000);
      write_reg(ssv_pkg::CSR_OSC_B_INC, 32'h7fff_ffff);
      write_reg(ssv_pkg::CSR_LFO_INC, 32'h7fff_ffff);
      write_reg(ssv_pkg::CSR_LFO_DEPTH, 32'h0000_ffff);
      write_reg(ssv_pkg::CSR_CUTOFF_BASE, 32'h0000_7fff);
      write_reg(ssv_pkg::CSR_CUTOFF_ENV, 32'h0000_7fff);
      write_reg(ssv_pkg::CSR_RESONANCE, 32'h0000_7fff);
      write_reg(ssv_pkg::CSR_OUTPUT_GAIN, 32'h0000_ffff);
      for (int i = 0; i < 8; i++) send_tick(i[0] ? 16'hffff : 16'h8000, i == 4, 1);
      req_tvalid <= 1'b0;
      drain();
      // cutoff driven below the floor, small increment on a, no feedback
      write_reg(ssv_pkg::CSR_OSC_A_INC, 32'h0123_4567);
      write_reg(ssv_pkg::CSR_CUTOFF_BASE, 32'h0000_0000);
      write_reg(ssv_pkg::CSR_CUTOFF_ENV, 32'h0000_8000);
      write_reg(ssv_pkg::CSR_RESONANCE, 32'h0000_0000);
      write_reg(ssv_pkg::CSR_OUTPUT_GAIN, 32'h0000_0000);
      for (int i = 0; i < 6; i++) send_tick(16'hffff, 1'b0, 0);
      drain();
      write_reg(ssv_pkg::CSR_OUTPUT_GAIN, 32'h0000_1000);
      write_reg(ssv_pkg::CSR_LFO_DEPTH, 32'h0000_0000);
      for (int i = 0; i < 6; i++) send_tick(16'h5555 << i[1:0], i == 0, 0);
      drain();

      // random phases, each under a fresh setting
      for (int p = 0; p < 5; p++) begin
         random_setting();
         send_random(110);
         // hold off until every expected sample has come
         drain();
      end

      drain();
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
